// ----- hdl/prd_pkg.sv -----
package prd_pkg;

  // input item: one byte of the capture file
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } prd_in_t;

  // result item; fields that do not belong to the kind are zero
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seconds;
    logic [31:0] subseconds;
    logic [31:0] captured_length;
    logic [31:0] original_length;
    logic [7:0]  payload_byte;
    logic        record_end;
    logic [31:0] link_layer;
    logic [15:0] version_major;
    logic [15:0] version_minor;
    logic [2:0]  status;
    logic        last;
  } prd_out_t;

  // up to two results per transfer, first one leaves first
  typedef struct packed {
    logic [1:0] count;
    prd_out_t   slot0;
    prd_out_t   slot1;
  } prd_push_t;

  typedef enum logic [1:0] {
    PhFileHdr,
    PhRecHdr,
    PhPayload,
    PhIgnore
  } prd_phase_e;

  localparam logic [1:0] KindFileHdr = 2'd0;
  localparam logic [1:0] KindRecHdr  = 2'd1;
  localparam logic [1:0] KindPayload = 2'd2;
  localparam logic [1:0] KindStatus  = 2'd3;

  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusShortHdr  = 3'd1;
  localparam logic [2:0] StatusBadMagic  = 3'd2;
  localparam logic [2:0] StatusTruncated = 3'd3;
  localparam logic [2:0] StatusPartRec   = 3'd4;

  localparam logic [31:0] MagicUsNative  = 32'hA1B2C3D4;
  localparam logic [31:0] MagicNsNative  = 32'hA1B23C4D;
  localparam logic [31:0] MagicUsSwapped = 32'hD4C3B2A1;
  localparam logic [31:0] MagicNsSwapped = 32'h4D3CB2A1;

  localparam logic [4:0] FileHdrLastPos = 5'd23;
  localparam logic [4:0] RecHdrLastPos  = 5'd15;

  localparam int unsigned PRD_FIFO_DEPTH = 4;

endpackage

// ----- hdl/prd_parser.sv -----
module prd_parser
  import prd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  prd_in_t   in_i,
  output prd_push_t push_o
);

  prd_phase_e  phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] word_q, word_d;
  logic        swap_q, swap_d;
  logic [2:0]  err_q, err_d;
  logic [15:0] major_q, major_d;
  logic [15:0] minor_q, minor_d;
  logic [31:0] secs_q, secs_d;
  logic [31:0] subs_q, subs_d;
  logic [31:0] capt_q, capt_d;
  logic [31:0] left_q, left_d;

  logic [1:0]  k;
  logic [31:0] base;
  logic [31:0] new_word;
  logic [31:0] left_dec;
  logic        has_data;
  logic [2:0]  st;
  prd_out_t    data_res;
  prd_out_t    stat_res;

  // byte lane within the word being assembled
  always_comb begin
    if (phase_q == PhFileHdr && pos_q >= 5'd4 && pos_q < 5'd8) begin
      k = {1'b0, pos_q[0]};
    end else begin
      k = pos_q[1:0];
    end
    base = (k == 2'd0) ? 32'd0 : word_q;
    if (swap_q) begin
      new_word = {base[23:0], in_i.data_byte};
    end else begin
      case (k)
        2'd0:    new_word = base | {24'd0, in_i.data_byte};
        2'd1:    new_word = base | {16'd0, in_i.data_byte, 8'd0};
        2'd2:    new_word = base | {8'd0, in_i.data_byte, 16'd0};
        default: new_word = base | {in_i.data_byte, 24'd0};
      endcase
    end
  end

  assign left_dec = left_q - 32'd1;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    word_d   = word_q;
    swap_d   = swap_q;
    err_d    = err_q;
    major_d  = major_q;
    minor_d  = minor_q;
    secs_d   = secs_q;
    subs_d   = subs_q;
    capt_d   = capt_q;
    left_d   = left_q;
    has_data = 1'b0;
    st       = err_q;
    data_res = '0;
    stat_res = '0;

    unique case (phase_q)
      PhFileHdr: begin
        word_d = new_word;
        if (pos_q == 5'd3) begin
          if (new_word == MagicUsNative || new_word == MagicNsNative) begin
            swap_d = 1'b0;
          end else if (new_word == MagicUsSwapped || new_word == MagicNsSwapped) begin
            swap_d = 1'b1;
          end else begin
            err_d = StatusBadMagic;
          end
        end else if (pos_q == 5'd5) begin
          major_d = new_word[15:0];
        end else if (pos_q == 5'd7) begin
          minor_d = new_word[15:0];
        end
        if (pos_q >= FileHdrLastPos) begin
          pos_d = '0;
          if (err_q != StatusOk) begin
            phase_d = PhIgnore;
          end else begin
            has_data               = 1'b1;
            data_res.kind          = KindFileHdr;
            data_res.link_layer    = new_word;
            data_res.version_major = major_q;
            data_res.version_minor = minor_q;
            phase_d                = PhRecHdr;
          end
          st = err_q;
        end else begin
          pos_d = pos_q + 5'd1;
          st    = StatusShortHdr;
        end
      end
      PhRecHdr: begin
        word_d = new_word;
        if (pos_q == 5'd3) begin
          secs_d = new_word;
        end else if (pos_q == 5'd7) begin
          subs_d = new_word;
        end else if (pos_q == 5'd11) begin
          capt_d = new_word;
        end
        if (pos_q >= RecHdrLastPos) begin
          has_data                 = 1'b1;
          data_res.kind            = KindRecHdr;
          data_res.seconds         = secs_q;
          data_res.subseconds      = subs_q;
          data_res.captured_length = capt_q;
          data_res.original_length = new_word;
          left_d                   = capt_q;
          pos_d                    = '0;
          phase_d = (capt_q != 32'd0) ? PhPayload : PhRecHdr;
          st      = (capt_q != 32'd0) ? StatusTruncated : StatusOk;
        end else begin
          pos_d = pos_q + 5'd1;
          st    = StatusPartRec;
        end
      end
      PhPayload: begin
        left_d                = left_dec;
        has_data              = 1'b1;
        data_res.kind         = KindPayload;
        data_res.payload_byte = in_i.data_byte;
        data_res.record_end   = (left_dec == 32'd0);
        if (left_dec == 32'd0) begin
          phase_d = PhRecHdr;
          pos_d   = '0;
          st      = StatusOk;
        end else begin
          st = StatusTruncated;
        end
      end
      default: begin
        st = err_q;
      end
    endcase

    stat_res.kind   = KindStatus;
    stat_res.status = st;
    stat_res.last   = 1'b1;

    // end of file: back to the reset state for the next file
    if (in_i.end_of_file) begin
      phase_d = PhFileHdr;
      pos_d   = '0;
      word_d  = '0;
      swap_d  = 1'b0;
      err_d   = StatusOk;
      major_d = '0;
      minor_d = '0;
      secs_d  = '0;
      subs_d  = '0;
      capt_d  = '0;
      left_d  = '0;
    end

    push_o = '0;
    if (fire_i) begin
      if (has_data) begin
        push_o.slot0 = data_res;
        push_o.slot1 = stat_res;
        push_o.count = in_i.end_of_file ? 2'd2 : 2'd1;
      end else if (in_i.end_of_file) begin
        push_o.slot0 = stat_res;
        push_o.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFileHdr;
      pos_q   <= '0;
      swap_q  <= 1'b0;
      err_q   <= StatusOk;
      word_q  <= '0;
      major_q <= '0;
      minor_q <= '0;
      secs_q  <= '0;
      subs_q  <= '0;
      capt_q  <= '0;
      left_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      swap_q  <= swap_d;
      err_q   <= err_d;
      word_q  <= word_d;
      major_q <= major_d;
      minor_q <= minor_d;
      secs_q  <= secs_d;
      subs_q  <= subs_d;
      capt_q  <= capt_d;
      left_q  <= left_d;
    end
  end

`ifndef ASSERT_OFF
  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && in_i.end_of_file |=> phase_q == PhFileHdr && pos_q == 5'd0)
    else $error("parser did not restart after end of file");

  a_file_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhFileHdr |-> pos_q <= FileHdrLastPos)
    else $error("file header position out of range");

  a_ignore_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIgnore |-> err_q == StatusBadMagic)
    else $error("ignore phase without a bad magic");
`endif

endmodule

// ----- hdl/prd_out_fifo.sv -----
module prd_out_fifo
  import prd_pkg::*;
#(
  parameter int unsigned Depth = PRD_FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  prd_push_t push_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output prd_out_t  out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  prd_out_t            mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d, wptr_nx, rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  // room for the two results one transfer can produce
  assign space_o     = (cnt_q <= CntW'(Depth - 2));
  assign wptr_nx     = ptr_inc(wptr_q);

  always_comb begin
    wptr_d = wptr_q;
    if (push_i.count == 2'd1) begin
      wptr_d = wptr_nx;
    end else if (push_i.count == 2'd2) begin
      wptr_d = ptr_inc(wptr_nx);
    end
    rptr_d = pop ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.slot0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_nx] <= push_i.slot1;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> space_o)
    else $error("push without room");

  a_pair_ends_file: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count == 2'd2 |-> push_i.slot1.last && !push_i.slot0.last)
    else $error("second result is not the end status");
`endif

endmodule

// ----- hdl/pcap_record_deframer_top.sv -----
// capture file record deframer
// in channel: one byte of a capture file per transfer (in_data_i.data_byte), with
//   end_of_file set on the final byte; in_valid_i / in_ready_o handshake
// out channel: parsed results (file header, record header, payload byte, end
//   status) as one struct per transfer; out_valid_o / out_ready_i handshake
// a transfer yields no result (inside a header or after a bad magic), one result,
//   or at end of file a data result followed by the end status
// results are registered in the result queue and offered from its head in order
// throughput: one input byte per cycle while the queue has room; the rate is
//   set by the combinational parse step, and the result queue drains one result
//   per cycle while out_ready_i is high; a file's end status is one more result
// the result queue holds Depth results; in_ready_o stays high while room for
//   two remains, so a stalled receiver back-pressures the input and nothing
//   is lost
// reset: parser back to the start of a file header, queue emptied; the parser
//   also returns to that state by itself after every end of file
module pcap_record_deframer_top
  import prd_pkg::*;
#(
  parameter int unsigned FifoDepth = PRD_FIFO_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  prd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output prd_out_t out_data_o
);

  logic      in_fire;
  logic      space;
  prd_push_t push;

  assign in_ready_o = space;
  assign in_fire    = in_valid_i && in_ready_o;

  // header walk, field assembly and payload count
  prd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .in_i   (in_data_i),
    .push_o (push)
  );

  // result queue, parts the two handshakes
  prd_out_fifo #(
    .Depth (FifoDepth)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- dv/prd_stream_checker.sv -----
`timescale 1ns / 100ps

module prd_stream_checker
  import prd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  prd_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  prd_out_t out_data_i,
  output int       pending_o,
  output int       fail_count_o
);

  // shadow parser state
  prd_phase_e  phase_q;
  logic [4:0]  pos_q;
  logic [31:0] word_q;
  logic        swap_q;
  logic [15:0] major_q;
  logic [15:0] minor_q;
  logic [31:0] secs_q;
  logic [31:0] subsecs_q;
  logic [31:0] capt_q;
  logic [31:0] left_q;
  logic [2:0]  err_q;

  prd_out_t expected_results[$];

  function automatic void clear_parser();
    phase_q   = PhFileHdr;
    pos_q     = '0;
    word_q    = '0;
    swap_q    = 1'b0;
    major_q   = '0;
    minor_q   = '0;
    secs_q    = '0;
    subsecs_q = '0;
    capt_q    = '0;
    left_q    = '0;
    err_q     = StatusOk;
  endfunction

  // queue a result at the tail
  function automatic void expect_result(input prd_out_t r);
    expected_results = {expected_results, r};
  endfunction

  // k is the byte index within the current field
  function automatic void gather_byte(input logic [7:0] b, input logic [1:0] k);
    if (k == 2'd0) word_q = '0;
    if (swap_q) begin
      word_q = {word_q[23:0], b};
    end else begin
      word_q = word_q | ({24'd0, b} << (8 * k));
    end
  endfunction

  task automatic parse_capture_byte(input prd_in_t item);
    prd_out_t   res;
    logic [2:0] end_status;
    logic [4:0] k;
    res = '0;
    end_status = StatusOk;
    case (phase_q)
      PhFileHdr: begin
        if (pos_q < 5'd4) k = pos_q;
        else if (pos_q < 5'd8) k = (pos_q - 5'd4) & 5'd1;
        else k = (pos_q - 5'd8) & 5'd3;
        gather_byte(item.data_byte, k[1:0]);
        if (pos_q == 5'd3) begin
          if (word_q == MagicUsNative || word_q == MagicNsNative) swap_q = 1'b0;
          else if (word_q == MagicUsSwapped || word_q == MagicNsSwapped) swap_q = 1'b1;
          else err_q = StatusBadMagic;
        end else if (pos_q == 5'd5) begin
          major_q = word_q[15:0];
        end else if (pos_q == 5'd7) begin
          minor_q = word_q[15:0];
        end
        if (pos_q >= FileHdrLastPos) begin
          pos_q = '0;
          if (err_q != StatusOk) begin
            phase_q = PhIgnore;
          end else begin
            res.kind          = KindFileHdr;
            res.link_layer    = word_q;
            res.version_major = major_q;
            res.version_minor = minor_q;
            expect_result(res);
            phase_q = PhRecHdr;
          end
          end_status = err_q;
        end else begin
          pos_q = pos_q + 5'd1;
          end_status = StatusShortHdr;
        end
      end
      PhRecHdr: begin
        gather_byte(item.data_byte, pos_q[1:0]);
        if (pos_q == 5'd3) secs_q = word_q;
        else if (pos_q == 5'd7) subsecs_q = word_q;
        else if (pos_q == 5'd11) capt_q = word_q;
        if (pos_q >= RecHdrLastPos) begin
          res.kind            = KindRecHdr;
          res.seconds         = secs_q;
          res.subseconds      = subsecs_q;
          res.captured_length = capt_q;
          res.original_length = word_q;
          expect_result(res);
          left_q = capt_q;
          pos_q  = '0;
          if (left_q != 0) begin
            phase_q    = PhPayload;
            end_status = StatusTruncated;
          end else begin
            phase_q    = PhRecHdr;
            end_status = StatusOk;
          end
        end else begin
          pos_q = pos_q + 5'd1;
          end_status = StatusPartRec;
        end
      end
      PhPayload: begin
        left_q = left_q - 32'd1;
        res.kind         = KindPayload;
        res.payload_byte = item.data_byte;
        res.record_end   = (left_q == 0);
        expect_result(res);
        if (left_q == 0) begin
          phase_q    = PhRecHdr;
          pos_q      = '0;
          end_status = StatusOk;
        end else begin
          end_status = StatusTruncated;
        end
      end
      default: begin
        end_status = err_q;
      end
    endcase
    // end of file: status goes after any data result of the same byte
    if (item.end_of_file) begin
      res = '0;
      res.kind   = KindStatus;
      res.status = end_status;
      res.last   = 1'b1;
      expect_result(res);
      clear_parser();
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o = fail_count_o + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    prd_out_t want;
    if (!rst_ni) begin
      clear_parser();
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) parse_capture_byte(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: kind %0d", out_data_i.kind);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_data_i.kind));
          check_field("seconds", want.seconds, out_data_i.seconds);
          check_field("subseconds", want.subseconds, out_data_i.subseconds);
          check_field("captured_length", want.captured_length, out_data_i.captured_length);
          check_field("original_length", want.original_length, out_data_i.original_length);
          check_field("payload_byte", 32'(want.payload_byte), 32'(out_data_i.payload_byte));
          check_field("record_end", 32'(want.record_end), 32'(out_data_i.record_end));
          check_field("link_layer", want.link_layer, out_data_i.link_layer);
          check_field("version_major", 32'(want.version_major),
                      32'(out_data_i.version_major));
          check_field("version_minor", 32'(want.version_minor),
                      32'(out_data_i.version_minor));
          check_field("status", 32'(want.status), 32'(out_data_i.status));
          check_field("last", 32'(want.last), 32'(out_data_i.last));
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import prd_pkg::*;

  localparam int ClkPeriod = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  prd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  prd_out_t out_data;

  // from the checker: results still owed by the block, and mismatches seen so far
  int awaited;
  int mismatches;

  // idling knobs, percent per cycle
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // long receiver hold-off: the stimulus bumps the request count, the receiver
  // process notices the change and counts the hold-off down on its own
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // capture file under construction, in file byte order
  logic [7:0] file_bytes[$];
  logic       file_swapped;
  int         items_sent = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  pcap_record_deframer_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  prd_stream_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .pending_o    (awaited),
    .fail_count_o (mismatches)
  );

  // receiver side: ready changes on the falling edge only
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // one more byte at the end of the file
  function automatic void append_byte(input logic [7:0] b);
    file_bytes = {file_bytes, b};
  endfunction

  // multi-byte fields go out least significant byte first for a native magic,
  // most significant first for a swapped one
  function automatic void put_field(input logic [31:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      if (file_swapped) append_byte(v[8 * (nbytes - 1 - i) +: 8]);
      else append_byte(v[8 * i +: 8]);
    end
  endfunction

  // 24-byte file header; zone, sigfigs and snap length are random filler
  function automatic void start_capture(input logic [31:0] magic, input logic [15:0] major,
                                        input logic [15:0] minor, input logic [31:0] link);
    file_bytes.delete();
    file_swapped = (magic == MagicUsSwapped || magic == MagicNsSwapped);
    // the magic word is always read low byte first
    for (int i = 0; i < 4; i++) append_byte(magic[8 * i +: 8]);
    put_field(32'(major), 2);
    put_field(32'(minor), 2);
    put_field($urandom, 4);
    put_field($urandom, 4);
    put_field($urandom, 4);
    put_field(link, 4);
  endfunction

  // record header plus body bytes; body may be shorter than captured to force truncation
  function automatic void add_record(input logic [31:0] secs, input logic [31:0] subsecs,
                                     input logic [31:0] captured, input logic [31:0] original,
                                     input int body);
    put_field(secs, 4);
    put_field(subsecs, 4);
    put_field(captured, 4);
    put_field(original, 4);
    repeat (body) append_byte(8'($urandom_range(255)));
  endfunction

  function automatic logic [31:0] pick_magic(input bit bad);
    logic [31:0] m;
    case ($urandom_range(3))
      0: m = MagicUsNative;
      1: m = MagicNsNative;
      2: m = MagicUsSwapped;
      default: m = MagicNsSwapped;
    endcase
    if (bad) begin
      // near misses by one flipped bit, or anything else that is not a magic
      if ($urandom_range(1) == 0) m = m ^ (32'd1 << $urandom_range(31));
      else begin
        do m = $urandom;
        while (m == MagicUsNative || m == MagicNsNative ||
               m == MagicUsSwapped || m == MagicNsSwapped);
      end
    end
    return m;
  endfunction

  // one byte transfer; called and returning at a falling edge, valid left high
  task automatic send_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{data_byte: b, end_of_file: eof};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // cut: number of bytes to send, 0 for the whole file; eof rides on the last one
  task automatic send_file(input int cut);
    int n;
    n = (cut > 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
    for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == n - 1);
    in_valid = 1'b0;
    items_sent = items_sent + n;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  // mostly well-formed files with random content, some cut short, some noise
  task automatic random_file();
    int          nrec;
    int          cut;
    logic [31:0] capt;
    if ($urandom_range(9) == 0) begin
      file_bytes.delete();
      repeat ($urandom_range(40, 1)) append_byte(8'($urandom_range(255)));
      send_file(0);
    end else begin
      start_capture(pick_magic($urandom_range(9) == 0), 16'($urandom), 16'($urandom),
                    $urandom);
      nrec = $urandom_range(4);
      repeat (nrec) begin
        if ($urandom_range(9) == 0) begin
          // huge captured length with a short body: ends truncated
          capt = $urandom;
          add_record($urandom, $urandom, capt, $urandom, $urandom_range(8));
        end else begin
          capt = ($urandom_range(5) == 0) ? 32'd0 : $urandom_range(12, 1);
          add_record($urandom, $urandom, capt, $urandom, capt);
        end
      end
      cut = ($urandom_range(3) == 0) ? $urandom_range(file_bytes.size(), 1) : 0;
      send_file(cut);
    end
  endtask

  initial begin
    int mark;
    int guard;

    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ---- directed files, no idling ----
    // native microsecond magic, field extremes, a record with bytes 00 and ff, then a zero-length record
    start_capture(MagicUsNative, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    add_record(32'hFFFF_FFFF, 32'h0, 32'd2, 32'hFFFF_FFFF, 0);
    append_byte(8'h00);
    append_byte(8'hFF);
    add_record(32'h0, 32'hFFFF_FFFF, 32'd0, 32'd0, 0);
    send_file(0);
    // swapped nanosecond magic, single-byte record
    start_capture(MagicNsSwapped, 16'h0000, 16'hFFFF, 32'h0);
    add_record(32'h1234_5678, 32'h9ABC_DEF0, 32'd1, 32'd1, 1);
    send_file(0);
    // file header only: header result and ok status on the same byte
    start_capture(MagicUsSwapped, 16'd2, 16'd4, 32'd1);
    send_file(0);
    start_capture(MagicNsNative, 16'd2, 16'd4, 32'd105);
    send_file(0);
    // short file header, down to a single-byte file
    start_capture(MagicUsNative, 16'd2, 16'd4, 32'd1);
    send_file(10);
    send_file(1);
    // bad magic: ignored tail, exactly 24 bytes, and cut inside the header
    start_capture(pick_magic(1'b1), 16'd2, 16'd4, 32'd1);
    send_file(24);
    repeat (5) append_byte(8'($urandom_range(255)));
    send_file(0);
    send_file(12);
    send_file(4);
    // payload running past the end of file
    start_capture(MagicNsNative, 16'd2, 16'd4, 32'd1);
    add_record(32'd7, 32'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3);
    send_file(0);
    // end of file right on the last record header byte with payload owed
    start_capture(MagicUsNative, 16'd2, 16'd4, 32'd1);
    add_record(32'd1, 32'd2, 32'd5, 32'd5, 5);
    send_file(40);
    // trailing partial record header
    start_capture(MagicUsSwapped, 16'd2, 16'd4, 32'd1);
    add_record(32'd1, 32'd2, 32'd3, 32'd3, 3);
    send_file(33);
    wait_drained();

    // ---- back-pressure: receiver holds off while the sender keeps offering ----
    hold_requests = hold_requests + 1;
    start_capture(MagicUsNative, 16'd2, 16'd4, 32'd1);
    add_record($urandom, $urandom, 32'd40, 32'd1500, 40);
    add_record($urandom, $urandom, 32'd30, 32'd30, 30);
    send_file(0);
    // sender pauses here until every result has come out
    wait_drained();

    // ---- random files over the idling phases ----
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
        default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      endcase
      mark = items_sent;
      while (items_sent - mark < 50) random_file();
      wait_drained();
    end

    // ---- wind down: let anything still in flight show up ----
    guard = 0;
    while (awaited != 0 && guard < 5000) begin
      @(negedge clk);
      guard = guard + 1;
    end
    repeat (8) @(negedge clk);

    if (mismatches == 0 && awaited == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
